>>> rtl/blm_pkg.sv
// Shared types, constants and saturation helpers for the Brent line minimizer.
// No dependencies; imported by every module of the block.
package blm_pkg;

  localparam logic signed [63:0] MAX48 = 64'sd140737488355327;
  localparam logic signed [63:0] MIN48 = -64'sd140737488355328;
  localparam logic signed [63:0] LIM62 = 64'sd2305843009213693951;
  // (3 - sqrt(5)) / 2 in Q0.32
  localparam logic signed [63:0] GOLDEN_Q32 = 64'sd1640531527;

  localparam logic [1:0] STAT_RUN   = 2'd0;
  localparam logic [1:0] STAT_CONV  = 2'd1;
  localparam logic [1:0] STAT_LIMIT = 2'd2;

  localparam logic [1:0] REG_LEFT  = 2'd0;
  localparam logic [1:0] REG_RIGHT = 2'd1;
  localparam logic [1:0] REG_RTOL  = 2'd2;

  function automatic logic signed [63:0] abs64(input logic signed [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v > MAX48) ? MAX48 : ((v < MIN48) ? MIN48 : v);
    return r[47:0];
  endfunction

  function automatic logic signed [63:0] sat62(input logic signed [63:0] v);
    return (v > LIM62) ? LIM62 : ((v < -LIM62) ? -LIM62 : v);
  endfunction

endpackage

>>> rtl/blm_mul.sv
// Shared multiplier: (a*b) >> sh, truncated toward zero, saturated to +-(2^61-1).
// One 32x32 partial product per cycle. Uses blm_pkg.
module blm_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  input  logic        [6:0]  sh_i,
  output logic               done_o,
  output logic signed [63:0] res_o
);
  import blm_pkg::*;

  logic [63:0]  ua_q, ub_q, prod_q;
  logic [127:0] acc_q, shifted;
  logic         neg_q, busy_q, done_q, sat;
  logic [6:0]   sh_q, off;
  logic [2:0]   cnt_q, pidx;
  logic [31:0]  pa, pb;
  logic [63:0]  mag_r;
  logic signed [63:0] res_q;

  assign pa      = cnt_q[0] ? ua_q[63:32] : ua_q[31:0];
  assign pb      = cnt_q[1] ? ub_q[63:32] : ub_q[31:0];
  assign pidx    = cnt_q - 3'd1;
  assign off     = 7'(({1'b0, pidx[0]} + {1'b0, pidx[1]})) << 5;
  assign shifted = acc_q >> sh_q;
  assign sat     = |shifted[127:61];
  assign mag_r   = sat ? 64'(LIM62) : {3'b0, shifted[60:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        ua_q   <= mag64(a_i);
        ub_q   <= mag64(b_i);
        neg_q  <= a_i[63] ^ b_i[63];
        sh_q   <= sh_i;
        acc_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (cnt_q < 3'd4) prod_q <= pa * pb;
        if (cnt_q != 3'd0 && cnt_q < 3'd5) acc_q <= acc_q + (128'(prod_q) << off);
        if (cnt_q == 3'd5) begin
          res_q  <= neg_q ? -$signed(mag_r) : $signed(mag_r);
          done_q <= 1'b1;
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q + 3'd1;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;
endmodule

>>> rtl/blm_div.sv
// Restoring divider: (p << FRACTION_BITS) / q, truncated toward zero, saturated.
// One quotient bit per cycle, 128 steps. Uses blm_pkg.
module blm_div #(
  parameter int FRACTION_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] p_i,
  input  logic signed [63:0] q_i,
  output logic               done_o,
  output logic signed [63:0] quo_o
);
  import blm_pkg::*;

  logic [127:0] num_q;
  logic [64:0]  rem_q, rem2;
  logic [63:0]  den_q;
  logic [60:0]  quo_q;
  logic [6:0]   idx_q;
  logic         neg_q, over_q, zero_q, busy_q, done_q, fire;

  assign rem2 = {rem_q[63:0], num_q[127]};
  assign fire = rem2 >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        num_q  <= 128'(mag64(p_i)) << FRACTION_BITS;
        den_q  <= 64'(q_i);
        zero_q <= (q_i <= 64'sd0);
        neg_q  <= p_i[63];
        rem_q  <= '0;
        quo_q  <= '0;
        over_q <= 1'b0;
        idx_q  <= 7'd127;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        num_q <= num_q << 1;
        rem_q <= fire ? rem2 - {1'b0, den_q} : rem2;
        if (idx_q >= 7'd61) begin
          if (fire) over_q <= 1'b1;
        end else begin
          quo_q <= {quo_q[59:0], fire};
        end
        if (idx_q == 7'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        idx_q <= idx_q - 7'd1;
      end
    end
  end

  // result is read on the done pulse, after the last step settled quo_q
  assign done_o = done_q;
  assign quo_o  = zero_q ? 64'sd0 :
                  (neg_q ? -(over_q ? LIM62 : $signed({3'b0, quo_q}))
                         :  (over_q ? LIM62 : $signed({3'b0, quo_q})));
endmodule

>>> rtl/brent_line_minimizer.sv
// Brent one-dimensional minimizer, objective evaluated outside the block.
// Depends on blm_pkg, blm_mul (shared multiplier) and blm_div (divider).
//
// Usage:
//   Slave channel: one transaction per item. tuser = mode (0 start, 1 value);
//   tdata = start_point [47:0], func_value [95:48].
//   Master channel: one transaction per input item. tuser = status
//   (0 running, 1 converged, 2 iteration limit); tdata = eval_point [47:0],
//   best_point [95:48], best_value [143:96]. eval_point is 0 unless running.
//   Config port: cfg_we_i writes register cfg_idx_i (0 left bound, 1 right
//   bound, 2 relative tolerance) on any edge; change only while idle.
// Sequencing:
//   Start items, values after the search has ended and values that reach the
//   iteration limit go straight to the output state. A value that leads to a
//   step runs a sequencer around one shared multiplier (2 to 9 products) and,
//   on a parabolic step, the bit-serial divider.
//   The input is not ready while the sequencer runs.
// Reset: search state zero, idle, registers at defaults; step terms not reset.
// Stall: one output register; while a result waits the next transaction may
//   be accepted and computed, then the block holds in its output state,
//   accepting nothing, until the receiver takes the waiting result.
module brent_line_minimizer #(
  parameter int MAX_ITERATIONS = 100,
  parameter int FRACTION_BITS  = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [95:0]   s_axis_tdata_i,  // start_point, func_value
  input  logic          s_axis_tuser_i,  // mode
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [143:0]  m_axis_tdata_o,  // eval_point, best_point, best_value
  output logic [1:0]    m_axis_tuser_o,  // status
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [47:0]   cfg_wdata_i
);
  import blm_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_FIRST, PH_EVAL, PH_DONE} phase_e;
  typedef enum logic [3:0] {
    ST_IDLE, ST_TOL, ST_TEST, ST_R, ST_Q, ST_P1, ST_P2,
    ST_C1, ST_C2, ST_C3, ST_DIV, ST_GOLD, ST_FIN, ST_OUT
  } state_e;

  state_e state_q;
  phase_e phase_q;

  logic signed [47:0] left_q, right_q;
  logic        [23:0] rtol_q;
  logic signed [47:0] a_q, b_q, x_q, w_q, v_q, fx_q, fw_q, fv_q, d_q, e_q, u_q;
  logic        [7:0]  iter_q;
  logic signed [63:0] tol_q, m_q, p_q, q_q, r_q, t_q;
  logic        [1:0]  stat_q;
  logic               wait_q;
  logic               out_vld_q;
  logic        [143:0] out_data_q;
  logic        [1:0]  out_user_q;

  // helpers
  logic signed [63:0] a64, b64, x64, t2, half, pnew, qnew, dd, uu, side;
  logic signed [47:0] el, fin;
  logic               accept, is_mul, mul_start, mul_done, div_start, div_done;
  logic signed [63:0] mul_a, mul_b, mul_res, div_res;
  logic        [6:0]  mul_sh;
  logic        [7:0]  iter_inc;

  assign a64  = 64'(a_q);
  assign b64  = 64'(b_q);
  assign x64  = 64'(x_q);
  assign t2   = tol_q <<< 1;
  assign half = (b64 - a64) >>> 1;
  assign side = (x64 < m_q) ? b64 : a64;
  assign el   = sat48(side - x64);
  assign fin  = fx_q;
  assign iter_inc = iter_q + 8'd1;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    is_mul = 1'b1;
    mul_a  = x64 - 64'(w_q);
    mul_b  = 64'(fx_q) - 64'(fv_q);
    mul_sh = 7'(FRACTION_BITS);
    unique case (state_q)
      ST_TOL:  begin mul_a = abs64(x64); mul_b = 64'({40'b0, rtol_q}); mul_sh = 7'd24; end
      ST_R:    ;
      ST_Q:    begin mul_a = x64 - 64'(v_q); mul_b = 64'(fx_q) - 64'(fw_q); end
      ST_P1:   begin mul_a = x64 - 64'(v_q); mul_b = q_q; end
      ST_P2:   begin mul_b = r_q; end
      ST_C1:   begin mul_a = q_q; mul_b = r_q; mul_sh = 7'(FRACTION_BITS + 1); end
      ST_C2:   begin mul_a = q_q; mul_b = a64 - x64; end
      ST_C3:   begin mul_a = q_q; mul_b = b64 - x64; end
      ST_GOLD: begin mul_a = 64'(el); mul_b = GOLDEN_Q32; mul_sh = 7'd32; end
      default: is_mul = 1'b0;
    endcase
  end

  assign mul_start = is_mul && !wait_q;
  assign div_start = (state_q == ST_DIV) && !wait_q;

  // parabola terms once the product of state ST_P2 is back
  always_comb begin
    logic signed [63:0] p0, q0;
    p0 = sat62(t_q - mul_res);
    q0 = sat62(sat62(q_q - r_q) <<< 1);
    pnew = (q0 > 64'sd0) ? -p0 : p0;
    qnew = (q0 > 64'sd0) ? q0 : -q0;
  end

  // parabolic step guard against the bracket ends
  always_comb begin
    logic signed [63:0] ds, us;
    ds = 64'(sat48(div_res));
    us = x64 + ds;
    dd = ((us - a64 < t2) || (b64 - us < t2)) ? ((x64 < m_q) ? tol_q : -tol_q) : ds;
  end

  always_comb begin
    logic signed [63:0] df;
    df = 64'(d_q);
    if (abs64(df) >= tol_q) uu = x64 + df;
    else if (df > 64'sd0)   uu = x64 + tol_q;
    else                    uu = x64 - tol_q;
  end

  blm_mul u_mul (
    .clk_i, .rst_ni,
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .sh_i    (mul_sh),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  blm_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk_i, .rst_ni,
    .start_i (div_start),
    .p_i     (p_q),
    .q_i     (q_q),
    .done_o  (div_done),
    .quo_o   (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_IDLE;
      left_q    <= '0;
      right_q   <= 48'sd50331648;
      rtol_q    <= 24'd16777;
      a_q <= '0; b_q <= '0; x_q <= '0; w_q <= '0; v_q <= '0;
      fx_q <= '0; fw_q <= '0; fv_q <= '0; d_q <= '0; e_q <= '0; u_q <= '0;
      iter_q    <= '0;
      stat_q    <= STAT_RUN;
      wait_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_LEFT:  left_q  <= cfg_wdata_i;
          REG_RIGHT: right_q <= cfg_wdata_i;
          REG_RTOL:  rtol_q  <= cfg_wdata_i[23:0];
          default:   ;
        endcase
      end
      // in ST_OUT the output register is reloaded below instead
      if (out_vld_q && m_axis_tready_i && state_q != ST_OUT) out_vld_q <= 1'b0;
      if (mul_start || div_start) wait_q <= 1'b1;

      unique case (state_q)
        ST_IDLE: if (accept) begin
          if (!s_axis_tuser_i) begin
            a_q <= left_q; b_q <= right_q;
            x_q <= s_axis_tdata_i[47:0]; w_q <= s_axis_tdata_i[47:0];
            v_q <= s_axis_tdata_i[47:0]; u_q <= s_axis_tdata_i[47:0];
            fx_q <= '0; fw_q <= '0; fv_q <= '0; d_q <= '0; e_q <= '0;
            iter_q  <= '0;
            phase_q <= PH_FIRST;
            stat_q  <= STAT_RUN;
            state_q <= ST_OUT;
          end else begin
            unique case (phase_q)
              PH_FIRST: begin
                fx_q <= s_axis_tdata_i[95:48];
                fw_q <= s_axis_tdata_i[95:48];
                fv_q <= s_axis_tdata_i[95:48];
                state_q <= ST_TOL;
              end
              PH_EVAL: begin
                // fold the new sample into bracket and best points
                if ($signed(s_axis_tdata_i[95:48]) <= fx_q) begin
                  if (u_q < x_q) b_q <= x_q; else a_q <= x_q;
                  v_q <= w_q; fv_q <= fw_q;
                  w_q <= x_q; fw_q <= fx_q;
                  x_q <= u_q; fx_q <= s_axis_tdata_i[95:48];
                end else begin
                  if (u_q < x_q) a_q <= u_q; else b_q <= u_q;
                  if ($signed(s_axis_tdata_i[95:48]) <= fw_q || w_q == x_q) begin
                    v_q <= w_q; fv_q <= fw_q;
                    w_q <= u_q; fw_q <= s_axis_tdata_i[95:48];
                  end else if ($signed(s_axis_tdata_i[95:48]) <= fv_q || v_q == x_q ||
                               v_q == w_q) begin
                    v_q <= u_q; fv_q <= s_axis_tdata_i[95:48];
                  end
                end
                iter_q <= iter_inc;
                if (iter_inc >= 8'(MAX_ITERATIONS)) begin
                  phase_q <= PH_DONE;
                  stat_q  <= STAT_LIMIT;
                  state_q <= ST_OUT;
                end else begin
                  state_q <= ST_TOL;
                end
              end
              PH_DONE: begin
                stat_q  <= (iter_q >= 8'(MAX_ITERATIONS)) ? STAT_LIMIT : STAT_CONV;
                state_q <= ST_OUT;
              end
              default: begin
                stat_q  <= STAT_CONV;
                state_q <= ST_OUT;
              end
            endcase
          end
        end
        ST_TOL: if (mul_done) begin
          wait_q  <= 1'b0;
          tol_q   <= 64'sd1 + mul_res;
          m_q     <= (a64 + b64) >>> 1;
          state_q <= ST_TEST;
        end
        ST_TEST: begin
          if (!(abs64(x64 - m_q) > t2 - half)) begin
            phase_q <= PH_DONE;
            stat_q  <= STAT_CONV;
            state_q <= ST_OUT;
          end else if (abs64(64'(e_q)) > tol_q) begin
            state_q <= ST_R;
          end else begin
            p_q <= '0; q_q <= '0; r_q <= '0;
            state_q <= ST_GOLD;
          end
        end
        ST_R: if (mul_done) begin
          wait_q <= 1'b0; r_q <= mul_res; state_q <= ST_Q;
        end
        ST_Q: if (mul_done) begin
          wait_q <= 1'b0; q_q <= mul_res; state_q <= ST_P1;
        end
        ST_P1: if (mul_done) begin
          wait_q <= 1'b0; t_q <= mul_res; state_q <= ST_P2;
        end
        ST_P2: if (mul_done) begin
          wait_q <= 1'b0;
          p_q <= pnew;
          q_q <= qnew;
          r_q <= 64'(e_q);
          e_q <= d_q;
          state_q <= (qnew > 64'sd0) ? ST_C1 : ST_GOLD;
        end
        ST_C1: if (mul_done) begin
          wait_q  <= 1'b0;
          state_q <= (abs64(p_q) < abs64(mul_res)) ? ST_C2 : ST_GOLD;
        end
        ST_C2: if (mul_done) begin
          wait_q  <= 1'b0;
          state_q <= (p_q < mul_res) ? ST_C3 : ST_GOLD;
        end
        ST_C3: if (mul_done) begin
          wait_q  <= 1'b0;
          state_q <= (p_q < mul_res) ? ST_DIV : ST_GOLD;
        end
        ST_DIV: if (div_done) begin
          wait_q  <= 1'b0;
          d_q     <= sat48(dd);
          state_q <= ST_FIN;
        end
        ST_GOLD: if (mul_done) begin
          wait_q  <= 1'b0;
          e_q     <= el;
          d_q     <= sat48(mul_res);
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          u_q     <= sat48(uu);
          phase_q <= PH_EVAL;
          stat_q  <= STAT_RUN;
          state_q <= ST_OUT;
        end
        ST_OUT: if (!out_vld_q || m_axis_tready_i) begin
          out_vld_q  <= 1'b1;
          out_user_q <= stat_q;
          out_data_q <= {fin, x_q, (stat_q == STAT_RUN) ? u_q : 48'sd0};
          state_q    <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
endmodule
